// File: rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked assertion, off while reset is asserted
`define FPTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a condition that must lead to a signal being high on the next edge
`define FPTC_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (sig)) else $error(msg);

`endif

// File: rtl/fptc_pkg.sv
// ---------------------------------------------------------------------------
// fptc_pkg
// Types, constants and helper functions for the tolerance compare pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fptc_pkg;

  // signed unbiased exponent, wide enough for products of subnormals
  typedef logic signed [12:0] exp_t;

  // unpacked number: value = man / 2^52 * 2^ue
  typedef struct packed {
    logic        sign;
    logic [52:0] man;
    exp_t        ue;
  } fnum_t;

  // rounder input: value = man / 2^63 * 2^ue, man normalised to bit 63
  typedef struct packed {
    logic [63:0] man;
    exp_t        ue;
    logic        sticky;
  } rnd_in_t;

  // early decision travelling beside the datapath
  typedef struct packed {
    logic        early;
    logic        early_val;
    logic [62:0] tkey;
  } ctl_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_USE_DOUBLE = 2'd0,
    CFG_ABS_MODE   = 2'd1,
    CFG_TOLERANCE  = 2'd2
  } cfg_idx_t;

  localparam exp_t BIAS_D = 13'sd1023;
  localparam exp_t BIAS_S = 13'sd127;
  localparam exp_t EMIN_D = -13'sd1022;
  localparam exp_t EMIN_S = -13'sd126;
  localparam exp_t EMAX_D = 13'sd1023;
  localparam exp_t EMAX_S = 13'sd127;

  localparam logic [62:0] INF_KEY_D = {11'h7FF, 52'b0};
  localparam logic [62:0] INF_KEY_S = {32'b0, 8'hFF, 23'b0};

  // magnitude bits of a pattern, sign removed
  function automatic logic [62:0] fp_mag(logic [63:0] b, logic dbl);
    return dbl ? b[62:0] : {32'b0, b[30:0]};
  endfunction

  function automatic logic fp_sign(logic [63:0] b, logic dbl);
    return dbl ? b[63] : b[31];
  endfunction

  // split a pattern into sign, mantissa with hidden bit and exponent
  function automatic fnum_t fp_unpack(logic [63:0] b, logic dbl);
    fnum_t       r;
    logic [10:0] ef;
    if (dbl) begin
      ef     = b[62:52];
      r.sign = b[63];
      r.man  = {ef != 11'd0, b[51:0]};
      r.ue   = exp_t'({2'b0, (ef == 11'd0) ? 11'd1 : ef}) - BIAS_D;
    end else begin
      ef     = {3'b0, b[30:23]};
      r.sign = b[31];
      r.man  = {ef != 11'd0, b[22:0], 29'b0};
      r.ue   = exp_t'({2'b0, (ef == 11'd0) ? 11'd1 : ef}) - BIAS_S;
    end
    return r;
  endfunction

  // leading zero count of a 64 bit word
  function automatic logic [6:0] lzc64(logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/fptc_in_if.sv
// ---------------------------------------------------------------------------
// fptc_in_if
// Input channel: one expected and actual pattern pair per transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fptc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] expected_bits;
  logic [63:0] actual_bits;

  modport source (output valid, output expected_bits, output actual_bits, input ready);
  modport sink (input valid, input expected_bits, input actual_bits, output ready);
endinterface

`default_nettype wire

// File: rtl/fptc_out_if.sv
// ---------------------------------------------------------------------------
// fptc_out_if
// Result channel: one within-tolerance bit per transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fptc_out_if;
  logic valid;
  logic ready;
  logic within_res;

  modport source (output valid, output within_res, input ready);
  modport sink (input valid, input within_res, output ready);
endinterface

`default_nettype wire

// File: rtl/fptc_unpack.sv
// ---------------------------------------------------------------------------
// fptc_unpack
// Three stages: field split, leading zero count, normalising shift.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fptc_unpack
  import fptc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic        use_double,
  input  wire logic [63:0] e_bits,
  input  wire logic [63:0] a_bits,
  input  wire logic [63:0] t_bits,
  output fnum_t            e_n,
  output fnum_t            a_n,
  output fnum_t            t_n,
  output logic             e_larger
);

  fnum_t      u1_e_r, u1_a_r, u1_t_r;
  logic       u1_el_r;
  fnum_t      u2_e_r, u2_a_r, u2_t_r;
  logic       u2_el_r;
  logic [5:0] u2_lze_r, u2_lza_r, u2_lzt_r;
  fnum_t      u3_e_r, u3_a_r, u3_t_r;
  logic       u3_el_r;

  // stage one: split fields, pick larger magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      u1_e_r  <= fp_unpack(e_bits, use_double);
      u1_a_r  <= fp_unpack(a_bits, use_double);
      u1_t_r  <= fp_unpack(t_bits, use_double);
      u1_el_r <= fp_mag(e_bits, use_double) >= fp_mag(a_bits, use_double);
    end
  end

  // stage two: leading zeros of each mantissa, zero counts as 53
  always_ff @(posedge clk) begin
    if (en) begin
      u2_e_r   <= u1_e_r;
      u2_a_r   <= u1_a_r;
      u2_t_r   <= u1_t_r;
      u2_el_r  <= u1_el_r;
      u2_lze_r <= 6'(lzc64({u1_e_r.man, 1'b1, 10'b0}));
      u2_lza_r <= 6'(lzc64({u1_a_r.man, 1'b1, 10'b0}));
      u2_lzt_r <= 6'(lzc64({u1_t_r.man, 1'b1, 10'b0}));
    end
  end

  // stage three: normalise so the hidden bit sits at the top
  always_ff @(posedge clk) begin
    if (en) begin
      u3_e_r.sign <= u2_e_r.sign;
      u3_e_r.man  <= u2_e_r.man << u2_lze_r;
      u3_e_r.ue   <= u2_e_r.ue - exp_t'({7'b0, u2_lze_r});
      u3_a_r.sign <= u2_a_r.sign;
      u3_a_r.man  <= u2_a_r.man << u2_lza_r;
      u3_a_r.ue   <= u2_a_r.ue - exp_t'({7'b0, u2_lza_r});
      u3_t_r.sign <= u2_t_r.sign;
      u3_t_r.man  <= u2_t_r.man << u2_lzt_r;
      u3_t_r.ue   <= u2_t_r.ue - exp_t'({7'b0, u2_lzt_r});
      u3_el_r     <= u2_el_r;
    end
  end

  assign e_n      = u3_e_r;
  assign a_n      = u3_a_r;
  assign t_n      = u3_t_r;
  assign e_larger = u3_el_r;

endmodule

`default_nettype wire

// File: rtl/fptc_arith.sv
// ---------------------------------------------------------------------------
// fptc_arith
// Four stages: alignment and partial products, add and product sum,
// leading zero count, normalisation into rounder format.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fptc_arith
  import fptc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  en,
  input  wire fnum_t e_n,
  input  wire fnum_t a_n,
  input  wire fnum_t t_n,
  input  wire logic  e_larger,
  output rnd_in_t    diff_o,
  output rnd_in_t    prod_o
);

  fnum_t        x, y;
  exp_t         d;
  logic [5:0]   dsh;
  logic [119:0] y_full;
  logic [55:0]  y56;

  // stage four registers
  logic [55:0]  a4_x_r, a4_y_r;
  logic         a4_sub_r;
  exp_t         a4_xue_r, a4_pe_r;
  logic [51:0]  a4_hh_r;
  logic [52:0]  a4_hl_r, a4_lh_r;
  logic [53:0]  a4_ll_r;
  // stage five registers
  logic [56:0]  a5_sum_r;
  exp_t         a5_xue_r, a5_pe_r;
  logic [105:0] a5_p_r;
  // stage six registers
  logic [56:0]  a6_sum_r;
  exp_t         a6_xue_r;
  logic [6:0]   a6_lz_r;
  rnd_in_t      a6_prod_r;
  // stage seven registers
  rnd_in_t      a7_diff_r, a7_prod_r;

  logic [63:0]  dnorm;

  // order operands by magnitude and align the smaller one
  always_comb begin
    x = e_larger ? e_n : a_n;
    y = e_larger ? a_n : e_n;
    d = x.ue - y.ue;
    if (d < 0) begin
      dsh = 6'd0;
    end else if (d > 13'sd63) begin
      dsh = 6'd63;
    end else begin
      dsh = d[5:0];
    end
    y_full = {y.man, 3'b0, 64'b0} >> dsh;
    y56    = y_full[119:64] | {55'b0, |y_full[63:0]};
  end

  // stage four: aligned operands and the four partial products
  always_ff @(posedge clk) begin
    if (en) begin
      a4_x_r   <= {x.man, 3'b0};
      a4_y_r   <= y56;
      a4_sub_r <= x.sign == y.sign;
      a4_xue_r <= x.ue;
      a4_pe_r  <= t_n.ue + x.ue;
      a4_hh_r  <= t_n.man[52:27] * x.man[52:27];
      a4_hl_r  <= t_n.man[52:27] * x.man[26:0];
      a4_lh_r  <= t_n.man[26:0] * x.man[52:27];
      a4_ll_r  <= t_n.man[26:0] * x.man[26:0];
    end
  end

  // stage five: magnitude add or subtract, product assembly
  always_ff @(posedge clk) begin
    if (en) begin
      a5_sum_r <= a4_sub_r ? ({1'b0, a4_x_r} - {1'b0, a4_y_r})
                           : ({1'b0, a4_x_r} + {1'b0, a4_y_r});
      a5_p_r   <= (106'(a4_hh_r) << 54) + ((106'(a4_hl_r) + 106'(a4_lh_r)) << 27)
                  + 106'(a4_ll_r);
      a5_xue_r <= a4_xue_r;
      a5_pe_r  <= a4_pe_r;
    end
  end

  // stage six: count leading zeros of the difference, one-bit product shift
  always_ff @(posedge clk) begin
    if (en) begin
      a6_sum_r <= a5_sum_r;
      a6_xue_r <= a5_xue_r;
      a6_lz_r  <= lzc64({a5_sum_r, 1'b1, 6'b0});
      if (a5_p_r[105]) begin
        a6_prod_r.man    <= a5_p_r[105:42];
        a6_prod_r.sticky <= |a5_p_r[41:0];
        a6_prod_r.ue     <= a5_pe_r + 13'sd1;
      end else begin
        a6_prod_r.man    <= a5_p_r[104:41];
        a6_prod_r.sticky <= |a5_p_r[40:0];
        a6_prod_r.ue     <= a5_pe_r;
      end
    end
  end

  assign dnorm = {a6_sum_r, 7'b0} << a6_lz_r;

  // stage seven: normalised difference
  always_ff @(posedge clk) begin
    if (en) begin
      a7_diff_r.man    <= dnorm;
      a7_diff_r.ue     <= a6_xue_r + 13'sd1 - exp_t'({6'b0, a6_lz_r});
      a7_diff_r.sticky <= 1'b0;
      a7_prod_r        <= a6_prod_r;
    end
  end

  assign diff_o = a7_diff_r;
  assign prod_o = a7_prod_r;

endmodule

`default_nettype wire

// File: rtl/fptc_round.sv
// ---------------------------------------------------------------------------
// fptc_round
// Two stages: subnormal shift, then round to nearest even and pack into a
// magnitude key that orders like the value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fptc_round
  import fptc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic         use_double,
  input  wire rnd_in_t      rin,
  output logic       [62:0] key
);

  exp_t         emin, emax, dn;
  logic [6:0]   sh;
  logic [127:0] shifted;

  logic [63:0]  r1_man_r;
  logic         r1_st_r;
  exp_t         r1_e_r;
  logic         r1_ovf_r;

  logic [52:0]  top;
  logic         rb, st, inc;
  logic [53:0]  mant;
  logic [63:0]  key64;
  logic [62:0]  key_r;

  // subnormal right shift amount
  always_comb begin
    emin = use_double ? EMIN_D : EMIN_S;
    emax = use_double ? EMAX_D : EMAX_S;
    dn   = emin - rin.ue;
    if (rin.ue >= emin) begin
      sh = 7'd0;
    end else if (dn > 13'sd64) begin
      sh = 7'd64;
    end else begin
      sh = dn[6:0];
    end
    shifted = {rin.man, 64'b0} >> sh;
  end

  // stage one: shifted mantissa, clamped exponent, overflow flag
  always_ff @(posedge clk) begin
    if (en) begin
      r1_man_r <= shifted[127:64];
      r1_st_r  <= rin.sticky | (|shifted[63:0]);
      r1_e_r   <= (rin.ue < emin) ? emin : rin.ue;
      r1_ovf_r <= rin.ue > emax;
    end
  end

  // round to nearest even, hidden bit carries into the exponent field
  always_comb begin
    if (use_double) begin
      top = r1_man_r[63:11];
      rb  = r1_man_r[10];
      st  = (|r1_man_r[9:0]) | r1_st_r;
    end else begin
      top = {29'b0, r1_man_r[63:40]};
      rb  = r1_man_r[39];
      st  = (|r1_man_r[38:0]) | r1_st_r;
    end
    inc   = rb & (st | top[0]);
    mant  = {1'b0, top} + {53'b0, inc};
    key64 = (64'(unsigned'(r1_e_r - emin)) << (use_double ? 52 : 23)) + 64'(mant);
  end

  // stage two: packed key, saturated to infinity
  always_ff @(posedge clk) begin
    if (en) begin
      if (r1_ovf_r) begin
        key_r <= use_double ? INF_KEY_D : INF_KEY_S;
      end else begin
        key_r <= key64[62:0];
      end
    end
  end

  assign key = key_r;

endmodule

`default_nettype wire

// File: rtl/fp_tolerance_compare_unit.sv
// ---------------------------------------------------------------------------
// fp_tolerance_compare_unit
// Approximate equality test of IEEE-754 pairs, binary32 or binary64.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries an expected and actual bit pattern pair; out_ch returns one
//   bit per pair, high when actual lies within tolerance of expected.
//   cfg_we/cfg_index/cfg_data write use_double, absolute_mode and the
//   tolerance pattern; write only while no pair is in flight.
//   From input transfer to result valid a pair passes three unpack stages,
//   four arithmetic stages (alignment and split 53x53 multiply, add, leading
//   zero count, normalise), two rounding stages and the compare register.
//   One pair per cycle unless out_ch stalls; every stage holds a valid bit.
//   Special cases (NaN, equality, infinities, negative, zero or infinite
//   tolerance) are decided at entry and ride alongside the datapath.
//   When out_ch is stalled the whole pipeline holds and in_ch.ready drops;
//   nothing is lost or repeated.
//   Reset empties the pipeline and sets binary32, relative mode, tolerance +0.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fp_tolerance_compare_unit
  import fptc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  fptc_in_if.sink          in_ch,
  fptc_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int NSTG = 10;

  logic        use_double_r, absolute_mode_r;
  logic [63:0] tolerance_bits_r;

  logic [NSTG-1:0] v_r;
  logic            adv;
  ctl_t            ctl_nxt;
  ctl_t            ctl_r [NSTG-1];
  logic            res_r;

  logic [62:0] emag, amag, tmag, inf_key;
  logic        se, sa, st;
  logic        nan_e, nan_a, inf_e, inf_a, nan_t, inf_t, zero_t, equal;

  fnum_t       e_n, a_n, t_n;
  logic        e_larger;
  rnd_in_t     diff_in, prod_in;
  logic [62:0] diff_key, prod_key;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_double_r     <= 1'b0;
      absolute_mode_r  <= 1'b0;
      tolerance_bits_r <= 64'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_USE_DOUBLE: use_double_r     <= cfg_data[0];
        CFG_ABS_MODE:   absolute_mode_r  <= cfg_data[0];
        CFG_TOLERANCE:  tolerance_bits_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances unless the result register is full and stalled
  assign adv         = !v_r[NSTG-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], in_ch.valid};
    end
  end

  // special case classification at entry
  always_comb begin
    inf_key = use_double_r ? INF_KEY_D : INF_KEY_S;
    emag    = fp_mag(in_ch.expected_bits, use_double_r);
    amag    = fp_mag(in_ch.actual_bits, use_double_r);
    tmag    = fp_mag(tolerance_bits_r, use_double_r);
    se      = fp_sign(in_ch.expected_bits, use_double_r);
    sa      = fp_sign(in_ch.actual_bits, use_double_r);
    st      = fp_sign(tolerance_bits_r, use_double_r);
    nan_e   = emag > inf_key;
    nan_a   = amag > inf_key;
    nan_t   = tmag > inf_key;
    inf_e   = emag == inf_key;
    inf_a   = amag == inf_key;
    inf_t   = tmag == inf_key;
    zero_t  = tmag == 63'd0;
    equal   = (emag == amag) && ((se == sa) || (emag == 63'd0));
    ctl_nxt.tkey      = tmag;
    ctl_nxt.early     = 1'b1;
    ctl_nxt.early_val = 1'b0;
    if (nan_e || nan_a) begin
      ctl_nxt.early_val = 1'b0;
    end else if (equal) begin
      ctl_nxt.early_val = 1'b1;
    end else if ((st && !zero_t) || inf_e || inf_a || nan_t) begin
      ctl_nxt.early_val = 1'b0;
    end else if (inf_t) begin
      ctl_nxt.early_val = 1'b1;
    end else if (zero_t) begin
      ctl_nxt.early_val = 1'b0;
    end else begin
      ctl_nxt.early = 1'b0;
    end
  end

  // decision line travelling beside the datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0] <= ctl_nxt;
      for (int i = 1; i < NSTG - 1; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  fptc_unpack u_unpack (
    .clk        (clk),
    .en         (adv),
    .use_double (use_double_r),
    .e_bits     (in_ch.expected_bits),
    .a_bits     (in_ch.actual_bits),
    .t_bits     (tolerance_bits_r),
    .e_n        (e_n),
    .a_n        (a_n),
    .t_n        (t_n),
    .e_larger   (e_larger)
  );

  fptc_arith u_arith (
    .clk      (clk),
    .en       (adv),
    .e_n      (e_n),
    .a_n      (a_n),
    .t_n      (t_n),
    .e_larger (e_larger),
    .diff_o   (diff_in),
    .prod_o   (prod_in)
  );

  fptc_round u_round_diff (
    .clk        (clk),
    .en         (adv),
    .use_double (use_double_r),
    .rin        (diff_in),
    .key        (diff_key)
  );

  fptc_round u_round_prod (
    .clk        (clk),
    .en         (adv),
    .use_double (use_double_r),
    .rin        (prod_in),
    .key        (prod_key)
  );

  // final compare into the result register
  always_ff @(posedge clk) begin
    if (adv) begin
      if (ctl_r[NSTG-2].early) begin
        res_r <= ctl_r[NSTG-2].early_val;
      end else if (absolute_mode_r) begin
        res_r <= diff_key <= ctl_r[NSTG-2].tkey;
      end else begin
        res_r <= diff_key <= prod_key;
      end
    end
  end

  assign out_ch.valid      = v_r[NSTG-1];
  assign out_ch.within_res = res_r;

  // checks
  `FPTC_ASSERT(a_empty_ready, !v_r[NSTG-1] |-> in_ch.ready, "ready low with empty result register")
  `FPTC_HOLD(a_stall_holds, !adv && v_r[NSTG-2], v_r[NSTG-2], "stage lost an item during a stall")
  `FPTC_ASSERT(a_diff_nonzero, v_r[NSTG-2] && !ctl_r[NSTG-2].early |-> diff_key != 63'd0, "difference of unequal values rounded to zero")

endmodule

`default_nettype wire
